[hdl/prim_mst_pkg.sv]
// Shared types and constants for the Prim spanning tree core.
package prim_mst_pkg;

  localparam int VERT_W     = 4;
  localparam int WEIGHT_W   = 14;
  localparam int TOTAL_W    = 18;
  localparam int CFG_W      = 5;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef logic [VERT_W-1:0]   vert_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [CFG_W-1:0]    vcount_t;

  // stored zero reads as this
  localparam weight_t NO_EDGE_COST = 14'd9999;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_RUN   = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_DISCONN = 1'b1;

  localparam vcount_t VCOUNT_RESET = 5'd16;
  localparam int      ADDR_LIMIT   = 16;

endpackage

[hdl/prim_mst_ram.sv]
// Generic simple dual-port RAM with registered read.
module prim_mst_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/prim_minimum_spanning_tree_core.sv]
// Dense Prim minimum spanning tree core over a symmetric weight matrix.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: req_type; tdata: row,col,weight
//  out_    | out | out_tvalid/tready  | tdata: from,to,weight,total; tlast; tuser
//  cfg_    | in  | cfg_valid/ready    | cfg_data: vertex_count
//
// After reset the matrix is cleared, one entry a cycle, all MAX_VERTICES^2 entries,
// while in_tready stays low. A write beat makes two RAM writes, the entry and its
// mirror, in S_WRA then S_WRB. A run makes up to n-1 passes over the matrix read
// port, fewer on a disconnect: each feeds n-1 elements, one per cycle, through the
// shared distance/min compare, then drains the registered read, plus the emit step.
// A stalled out_ channel holds the run at its next emit; the core is not ready
// until a run ends.
module prim_minimum_spanning_tree_core #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: row_vertex[3:0], col_vertex[7:4], edge_weight_in[21:8], zero pad
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [prim_mst_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: req_type[0]
  input  logic [0:0]                           in_tuser,
  // out_tdata: tree_from[3:0], tree_to[7:4], edge_weight_out[21:8],
  //            run_total[39:22]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [prim_mst_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                                 out_tlast,
  // out_tuser: status[0]
  output logic [0:0]                           out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [prim_mst_pkg::CFG_W-1:0]       cfg_data
);

  localparam int NV    = (MAX_VERTICES < prim_mst_pkg::ADDR_LIMIT) ?
                         MAX_VERTICES : prim_mst_pkg::ADDR_LIMIT;
  localparam int IW    = $clog2(NV);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRA,
    S_WRB,
    S_PASS,
    S_EMIT
  } state_t;

  state_t state_r;

  prim_mst_pkg::vcount_t vcount_r;
  prim_mst_pkg::vcount_t n_act;

  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] wr_a_r;
  logic [AW-1:0] wr_b_r;
  prim_mst_pkg::weight_t wr_d_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  prim_mst_pkg::weight_t ram_wdata;
  logic [AW-1:0]         ram_raddr;
  prim_mst_pkg::weight_t ram_rdata;

  logic [NV-1:0]         in_tree_r;
  prim_mst_pkg::weight_t dist_r [NV];
  prim_mst_pkg::vert_t   par_r  [NV];

  prim_mst_pkg::vcount_t iss_i_r;
  logic                  proc_v_r;
  prim_mst_pkg::vert_t   proc_i_r;
  prim_mst_pkg::vert_t   pick_r;
  logic                  init_r;
  prim_mst_pkg::weight_t min_r;
  prim_mst_pkg::vert_t   cand_r;
  prim_mst_pkg::vert_t   cand_par_r;
  prim_mst_pkg::vcount_t sel_left_r;
  prim_mst_pkg::total_t  total_r;

  logic                  out_valid_r;
  prim_mst_pkg::vert_t   out_from_r;
  prim_mst_pkg::vert_t   out_to_r;
  prim_mst_pkg::weight_t out_w_r;
  prim_mst_pkg::total_t  out_total_r;
  logic                  out_last_r;
  logic                  out_status_r;

  // input fields
  prim_mst_pkg::vert_t   in_row;
  prim_mst_pkg::vert_t   in_col;
  prim_mst_pkg::weight_t in_w;
  logic                  in_req;
  logic                  in_fire;
  logic                  wr_ignore;
  prim_mst_pkg::weight_t wr_store;

  // shared compare unit
  logic [IW-1:0]         pi;
  prim_mst_pkg::weight_t cost;
  logic                  take_c;
  prim_mst_pkg::weight_t newd;
  logic                  issuing;
  logic                  out_free;
  logic                  found;
  prim_mst_pkg::total_t  total_sum;
  prim_mst_pkg::vcount_t n_minus1;

  assign in_row  = in_tdata[3:0];
  assign in_col  = in_tdata[7:4];
  assign in_w    = in_tdata[21:8];
  assign in_req  = in_tuser[0];
  assign in_fire = in_tvalid && in_tready;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    n_act = vcount_r;
    if (vcount_r < 5'd2) begin
      n_act = 5'd2;
    end else if (vcount_r > prim_mst_pkg::CFG_W'(NV)) begin
      n_act = prim_mst_pkg::CFG_W'(NV);
    end
  end

  assign n_minus1 = n_act - 5'd1;

  assign wr_ignore = (in_row == in_col) || (32'(in_row) >= MAX_VERTICES) ||
                     (32'(in_col) >= MAX_VERTICES);
  assign wr_store  = (in_w >= prim_mst_pkg::NO_EDGE_COST) ? '0 : in_w;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_WRA: begin
        ram_we    = 1'b1;
        ram_waddr = wr_a_r;
        ram_wdata = wr_d_r;
      end
      S_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = wr_b_r;
        ram_wdata = wr_d_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // column pick of row i; matrix is symmetric so cost(i,pick) = cost(pick,i)
  assign ram_raddr = AW'(iss_i_r[3:0]) * AW'(MAX_VERTICES) + AW'(pick_r);

  prim_mst_ram #(
    .WIDTH (prim_mst_pkg::WEIGHT_W),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pi      = proc_i_r[IW-1:0];
  assign cost    = (ram_rdata == '0) ? prim_mst_pkg::NO_EDGE_COST : ram_rdata;
  assign take_c  = init_r || (cost < dist_r[pi]);
  assign newd    = take_c ? cost : dist_r[pi];
  assign issuing = (iss_i_r != n_act);
  assign out_free  = !out_valid_r || out_tready;
  assign found     = (min_r != prim_mst_pkg::NO_EDGE_COST);
  assign total_sum = total_r + prim_mst_pkg::TOTAL_W'(min_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      vcount_r    <= prim_mst_pkg::VCOUNT_RESET;
      clr_addr_r  <= '0;
      in_tree_r   <= '0;
      proc_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
      // the emit step reloads the output register itself
      if (out_valid_r && out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (32'(clr_addr_r) == DEPTH - 1) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            if (in_req == prim_mst_pkg::REQ_RUN) begin
              in_tree_r  <= NV'(1);
              pick_r     <= '0;
              init_r     <= 1'b1;
              iss_i_r    <= 5'd1;
              proc_v_r   <= 1'b0;
              min_r      <= prim_mst_pkg::NO_EDGE_COST;
              total_r    <= '0;
              sel_left_r <= n_minus1;
              state_r    <= S_PASS;
            end else if (!wr_ignore) begin
              wr_a_r  <= AW'(in_row) * AW'(MAX_VERTICES) + AW'(in_col);
              wr_b_r  <= AW'(in_col) * AW'(MAX_VERTICES) + AW'(in_row);
              wr_d_r  <= wr_store;
              state_r <= S_WRA;
            end
          end
        end

        S_WRA: begin
          state_r <= S_WRB;
        end

        S_WRB: begin
          state_r <= S_IDLE;
        end

        S_PASS: begin
          if (issuing) begin
            iss_i_r <= iss_i_r + 5'd1;
          end
          proc_v_r <= issuing;
          proc_i_r <= iss_i_r[3:0];
          // relax vertex, and track the next pick in the same beat
          if (proc_v_r && !in_tree_r[pi]) begin
            dist_r[pi] <= newd;
            if (take_c) begin
              par_r[pi] <= pick_r;
            end
            if (newd < min_r) begin
              min_r      <= newd;
              cand_r     <= proc_i_r;
              cand_par_r <= take_c ? pick_r : par_r[pi];
            end
          end
          if (!issuing && !proc_v_r) begin
            state_r <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (!found) begin
              out_from_r   <= '0;
              out_to_r     <= '0;
              out_w_r      <= '0;
              out_total_r  <= total_r;
              out_last_r   <= 1'b1;
              out_status_r <= prim_mst_pkg::ST_DISCONN;
              state_r      <= S_IDLE;
            end else begin
              out_from_r   <= cand_par_r;
              out_to_r     <= cand_r;
              out_w_r      <= min_r;
              out_total_r  <= total_sum;
              out_last_r   <= (sel_left_r == 5'd1);
              out_status_r <= prim_mst_pkg::ST_OK;
              total_r      <= total_sum;
              in_tree_r[cand_r[IW-1:0]] <= 1'b1;
              pick_r       <= cand_r;
              init_r       <= 1'b0;
              sel_left_r   <= sel_left_r - 5'd1;
              iss_i_r      <= 5'd1;
              min_r        <= prim_mst_pkg::NO_EDGE_COST;
              state_r      <= (sel_left_r == 5'd1) ? S_IDLE : S_PASS;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_w_r, out_to_r, out_from_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  // the matrix is not written while a run reads it
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS || state_r == S_EMIT) |-> !ram_we)
    else $error("matrix write during run");

  // no input accepted before the clearing sweep ends
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("ready during matrix clear");

  // a disconnect report always closes its run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] == prim_mst_pkg::ST_DISCONN) |-> out_tlast)
    else $error("disconnect result without last flag");

  // pipelined element only ever retires inside a pass
  assert property (@(posedge clk) disable iff (!rst_n)
    proc_v_r |-> (state_r == S_PASS))
    else $error("element in flight outside pass");

  // emitted edges add exactly their weight to the running total
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free && found) |=>
      (out_tdata[39:22] == out_tdata[21:8] + $past(total_r)))
    else $error("running total mismatch");

endmodule

[sim/prim_minimum_spanning_tree_core_tb.sv]
// Self-checking testbench for the Prim spanning tree core: directed and random traffic.
module prim_minimum_spanning_tree_core_tb;
  import prim_mst_pkg::*;

  localparam int MAX_V = 16;

  typedef struct packed {
    logic    req_type;
    vert_t   row;
    vert_t   col;
    weight_t wt;
  } mst_req_t;

  typedef struct packed {
    vert_t   src_v;
    vert_t   dst_v;
    weight_t wt;
    total_t  total;
    logic    last;
    logic    status;
  } tree_edge_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic [0:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  // shadow of the block's state
  weight_t adj [MAX_V*MAX_V];
  vcount_t vcount_cfg;

  mst_req_t   req_q[$];
  tree_edge_t tree_edge_q[$];
  mst_req_t   cur_req;

  int send_idle = 38;
  int recv_idle = 83;
  int errors = 0;
  int reqs_sent = 0;
  int runs_sent = 0;
  int edges_checked = 0;

  vcount_t vcount_plan [12] = '{5'd5, 5'd2, 5'd31, 5'd0, 5'd9, 5'd16, 5'd1, 5'd12,
                                5'd3, 5'd20, 5'd7, 5'd16};

  prim_minimum_spanning_tree_core #(.MAX_VERTICES(MAX_V)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int link_cost(int a, int b);
    weight_t w;
    w = adj[a*MAX_V + b];
    return (w == '0) ? int'(NO_EDGE_COST) : int'(w);
  endfunction

  // Prim from vertex 0; queues one tree edge per added vertex, or a disconnect beat
  function automatic void grow_tree();
    int n, lim, k, i, pick, min_d, c;
    int best_d [MAX_V];
    int par [MAX_V];
    bit joined [MAX_V];
    int unsigned sum;
    bit found;
    tree_edge_t te;
    lim = (MAX_V < ADDR_LIMIT) ? MAX_V : ADDR_LIMIT;
    n = int'(vcount_cfg);
    if (n < 2) n = 2;
    if (n > lim) n = lim;
    sum = 0;
    for (i = 1; i < n; i++) begin
      joined[i] = 1'b0;
      best_d[i] = link_cost(0, i);
      par[i] = 0;
    end
    for (k = n - 1; k > 0; k--) begin
      found = 1'b0;
      min_d = int'(NO_EDGE_COST);
      pick = 0;
      // strict compare: lowest index wins a tie
      for (i = 1; i < n; i++) begin
        if (!joined[i] && best_d[i] < min_d) begin
          pick = i;
          min_d = best_d[i];
          found = 1'b1;
        end
      end
      if (!found) begin
        te = '{src_v: '0, dst_v: '0, wt: '0, total: total_t'(sum), last: 1'b1,
               status: ST_DISCONN};
        tree_edge_q.push_back(te);
        return;
      end
      joined[pick] = 1'b1;
      sum += best_d[pick];
      te = '{src_v: vert_t'(par[pick]), dst_v: vert_t'(pick), wt: weight_t'(best_d[pick]),
             total: total_t'(sum), last: (k == 1), status: ST_OK};
      for (i = 1; i < n; i++) begin
        c = link_cost(i, pick);
        if (!joined[i] && c < best_d[i]) begin
          best_d[i] = c;
          par[i] = pick;
        end
      end
      tree_edge_q.push_back(te);
    end
  endfunction

  function automatic void apply_request(mst_req_t r);
    weight_t w;
    if (r.req_type == REQ_RUN) begin
      grow_tree();
    end else if (r.row != r.col && int'(r.row) < MAX_V && int'(r.col) < MAX_V) begin
      w = (r.wt >= NO_EDGE_COST) ? weight_t'(0) : r.wt;
      adj[r.row*MAX_V + r.col] = w;
      adj[r.col*MAX_V + r.row] = w;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(cur_req);
        reqs_sent++;
        if (cur_req.req_type == REQ_RUN) runs_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_req = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.req_type;
          in_tdata <= {2'b00, cur_req.wt, cur_req.col, cur_req.row};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    tree_edge_t exp_e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (tree_edge_q.size() == 0) begin
          $error("unexpected result beat: tdata %0h tlast %0b tuser %0b",
                 out_tdata, out_tlast, out_tuser);
          errors++;
        end else begin
          exp_e = tree_edge_q.pop_front();
          edges_checked++;
          if (out_tdata[3:0] !== exp_e.src_v) begin
            $error("tree_from: expected %0d, got %0d", exp_e.src_v, out_tdata[3:0]);
            errors++;
          end
          if (out_tdata[7:4] !== exp_e.dst_v) begin
            $error("tree_to: expected %0d, got %0d", exp_e.dst_v, out_tdata[7:4]);
            errors++;
          end
          if (out_tdata[21:8] !== exp_e.wt) begin
            $error("edge_weight_out: expected %0d, got %0d", exp_e.wt, out_tdata[21:8]);
            errors++;
          end
          if (out_tdata[39:22] !== exp_e.total) begin
            $error("run_total: expected %0d, got %0d", exp_e.total, out_tdata[39:22]);
            errors++;
          end
          if (out_tlast !== exp_e.last) begin
            $error("last_edge: expected %0b, got %0b", exp_e.last, out_tlast);
            errors++;
          end
          if (out_tuser[0] !== exp_e.status) begin
            $error("status: expected %0b, got %0b", exp_e.status, out_tuser[0]);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic void add_req(logic kind, int row, int col, int wt);
    req_q.push_back('{req_type: kind, row: vert_t'(row), col: vert_t'(col),
                      wt: weight_t'(wt)});
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(6, 1);
      4:          return 0;
      5:          return $urandom_range(16383);
      6:          return int'(NO_EDGE_COST);
      default:    return $urandom_range(9998, 1);
    endcase
  endfunction

  // mostly a spanning tree over the active vertices plus stray edges, then a run
  function automatic int add_group(int n);
    int k, j, cnt;
    cnt = 0;
    if ($urandom_range(3) != 0) begin
      for (k = 1; k < n; k++) begin
        j = $urandom_range(k - 1, 0);
        if ($urandom_range(1))
          add_req(REQ_WRITE, k, j, $urandom_range(1) ? $urandom_range(6, 1)
                                                     : $urandom_range(9998, 1));
        else
          add_req(REQ_WRITE, j, k, $urandom_range(6, 1));
        cnt++;
      end
      repeat ($urandom_range(3)) begin
        add_req(REQ_WRITE, $urandom_range(15), $urandom_range(15), pick_weight());
        cnt++;
      end
    end else begin
      repeat ($urandom_range(4, 1)) begin
        add_req(REQ_WRITE, $urandom_range(n - 1), $urandom_range(n - 1), pick_weight());
        cnt++;
      end
    end
    add_req(REQ_RUN, $urandom_range(15), $urandom_range(15), $urandom_range(16383));
    return cnt + 1;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (req_q.size() != 0 || in_tvalid || tree_edge_q.size() != 0);
    // a trailing write may still be in progress
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vertex_count(input vcount_t v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    vcount_cfg = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stim
    int p, i, budget, n;
    foreach (adj[i]) adj[i] = '0;
    vcount_cfg = VCOUNT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty graph, weight limits, diagonal, then a chain with a tie
    add_req(REQ_RUN, 0, 0, 0);
    add_req(REQ_WRITE, 0, 1, 9998);
    add_req(REQ_WRITE, 1, 2, 16383);
    add_req(REQ_WRITE, 2, 2, 5);
    add_req(REQ_WRITE, 0, 2, int'(NO_EDGE_COST));
    add_req(REQ_RUN, 15, 15, 16383);
    for (i = 0; i < 15; i++) add_req(REQ_WRITE, i, i + 1, (i % 3) + 1);
    add_req(REQ_WRITE, 15, 0, 1);
    add_req(REQ_RUN, 0, 0, 0);
    wait_drained();

    for (p = 0; p < 12; p++) begin
      if (p == 4) begin
        send_idle = 83;
        recv_idle = 38;
      end else if (p == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_vertex_count(vcount_plan[p]);
      n = int'(vcount_plan[p]);
      if (n < 2) n = 2;
      if (n > MAX_V) n = MAX_V;
      budget = 6;
      @(negedge clk);
      while (budget > 0) budget -= add_group(n);
      wait_drained();
    end

    repeat (300) @(posedge clk);
    $display("Sent %0d requests (%0d spanning tree runs) over %0d vertex-count settings;",
             reqs_sent, runs_sent, 13);
    $display("checked %0d tree edge beats, %0d mismatches.", edges_checked, errors);
    if (errors == 0 && tree_edge_q.size() == 0) begin
      $display("prim_minimum_spanning_tree_core_tb: PASS");
    end else begin
      $display("prim_minimum_spanning_tree_core_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("prim_minimum_spanning_tree_core_tb: FAIL");
    $finish;
  end

endmodule
